// ===== src/mcspmv_pkg.sv =====
package mcspmv_pkg;

    localparam int VEC_DEPTH   = 4096;
    localparam int ADDR_W      = $clog2(VEC_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 1;

    // Request type codes.
    localparam logic [1:0] REQ_VEC_WR  = 2'd0;
    localparam logic [1:0] REQ_MASK_WR = 2'd1;
    localparam logic [1:0] REQ_ENTRY   = 2'd2;
    localparam logic [1:0] REQ_EMPTY   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COL_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SKIP = 1'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        index;
        logic [11:0]        row_number;
        logic signed [31:0] value;
        logic               mask_bit;
        logic               last_in_row;
    } t_in_req;

    typedef struct packed {
        logic [11:0]        result_row;
        logic signed [63:0] row_sum;
        logic               saturated;
    } t_out_res;

    // Classified request as it sits in the queue.
    typedef struct packed {
        logic [1:0]         kind;
        logic               closes;
        logic [11:0]        index;
        logic [11:0]        row_number;
        logic signed [31:0] value;
        logic               mask_bit;
    } t_cmd;

endpackage

// ===== src/mcspmv_front.sv =====
module mcspmv_front import mcspmv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in_req i_in_req,
    output logic    o_in_stall,
    input  logic    i_clearing,
    input  logic    i_pop,
    output logic    o_head_valid,
    output t_cmd    o_head
);

    t_cmd              in_cmd;
    logic              push;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    always_comb begin
        in_cmd.kind       = i_in_req.req_type;
        in_cmd.closes     = (i_in_req.req_type == REQ_EMPTY) ||
                            (i_in_req.req_type == REQ_ENTRY && i_in_req.last_in_row);
        in_cmd.index      = i_in_req.index;
        in_cmd.row_number = i_in_req.row_number;
        in_cmd.value      = i_in_req.value;
        in_cmd.mask_bit   = i_in_req.mask_bit;
    end

    assign o_in_stall   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH)) || i_clearing;
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        case ({push, i_pop})
            2'b10:   n_count = r_count + (QPTR_W+1)'(1);
            2'b01:   n_count = r_count - (QPTR_W+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue popped while empty");

endmodule

// ===== src/mcspmv_back.sv =====
module mcspmv_back import mcspmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_head_valid,
    input  t_cmd                 i_head,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    output t_out_res             o_out_res,
    input  logic                 i_out_stall
);

    logic               r_col_mask_en;
    logic               r_row_skip_en;

    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic signed [31:0] r_vec_mem [VEC_DEPTH];
    logic               r_good_mask [VEC_DEPTH];

    logic               adv;
    logic [ADDR_W-1:0]  col_addr;
    logic [ADDR_W-1:0]  row_addr;
    logic               vec_we;
    logic               mask_we;
    logic [ADDR_W-1:0]  mask_waddr;
    logic               mask_wdata;

    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic signed [31:0] r_s1_vec;
    logic               r_s1_col_good;
    logic               r_s1_row_good;

    logic               r_s2_valid;
    logic               r_s2_closes;
    logic               r_s2_empty;
    logic [11:0]        r_s2_row;
    logic               r_s2_incl;
    logic               r_s2_skip;
    logic signed [63:0] r_s2_prod;

    logic signed [63:0] r_acc;
    logic               r_sat;
    logic signed [63:0] sum_raw;
    logic signed [63:0] sum_sat;
    logic               ovf;
    logic signed [63:0] acc_new;
    logic               flag_new;

    logic               r_out_valid;
    t_out_res           r_out;

    // The pipeline freezes while a finished result waits on a stalled receiver.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_pop      = i_head_valid && adv && !r_clearing;
    assign o_clearing = r_clearing;
    assign col_addr   = i_head.index[ADDR_W-1:0];
    assign row_addr   = i_head.row_number[ADDR_W-1:0];
    assign vec_we     = o_pop && (i_head.kind == REQ_VEC_WR);
    assign mask_we    = r_clearing || (o_pop && (i_head.kind == REQ_MASK_WR));
    assign mask_waddr = r_clearing ? r_clr_addr : col_addr;
    assign mask_wdata = r_clearing ? 1'b1 : i_head.mask_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_mask_en <= 1'b0;
            r_row_skip_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COL_MASK: r_col_mask_en <= i_cfg_data;
                CFG_ROW_SKIP: r_row_skip_en <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // After reset every mask entry is set back to good, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(VEC_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vec_mem[col_addr] <= i_head.value;
        end
        if (o_pop) begin
            r_s1_vec <= r_vec_mem[col_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            r_good_mask[mask_waddr] <= mask_wdata;
        end
        if (o_pop) begin
            r_s1_col_good <= r_good_mask[col_addr];
            r_s1_row_good <= r_good_mask[row_addr];
            r_s1_cmd      <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= o_pop && (i_head.kind == REQ_ENTRY || i_head.kind == REQ_EMPTY);
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_closes <= r_s1_cmd.closes;
            r_s2_empty  <= (r_s1_cmd.kind == REQ_EMPTY);
            r_s2_row    <= r_s1_cmd.row_number;
            r_s2_incl   <= !(r_col_mask_en && !r_s1_col_good);
            r_s2_skip   <= r_row_skip_en && !r_s1_row_good;
            r_s2_prod   <= $signed(r_s1_cmd.value) * $signed(r_s1_vec);
        end
    end

    always_comb begin
        sum_raw  = r_acc + r_s2_prod;
        ovf      = (r_acc[63] == r_s2_prod[63]) && (sum_raw[63] != r_acc[63]);
        if (ovf) begin
            sum_sat = r_acc[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        end else begin
            sum_sat = sum_raw;
        end
        acc_new  = r_s2_incl ? sum_sat : r_acc;
        flag_new = r_sat || (r_s2_incl && ovf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_closes;
            if (r_s2_valid) begin
                if (r_s2_closes) begin
                    r_acc <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_acc <= acc_new;
                    r_sat <= flag_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_closes) begin
            r_out.result_row <= r_s2_row;
            if (r_s2_empty || r_s2_skip) begin
                r_out.row_sum   <= '0;
                r_out.saturated <= 1'b0;
            end else begin
                r_out.row_sum   <= acc_new;
                r_out.saturated <= flag_new;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_pop)
        else $error("request taken during mask clearing");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_acc) && $stable(r_out)))
        else $error("accumulator or result moved under output stall");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2_closes))
        else $error("result without a closing request");

endmodule

// ===== src/masked_csr_spmv_top.sv =====
// Streaming CSR sparse matrix times dense vector with a per-index good mask.
// Input channel (i_in_valid / o_in_stall, payload i_in_req) carries vector
// writes, mask writes, matrix entries and empty-row markers in one stream.
// Output channel (o_out_valid / i_out_stall, payload o_out_res) carries one
// Q32.32 row sum per closing entry or empty row, with a saturation flag.
// The configuration channel (i_cfg_valid / o_cfg_ready) sets the column-mask
// and row-skip enables; it is always ready.
// Throughput is one request per cycle while the receiver does not stall,
// set by the saturating accumulate loop and the one write / two read
// ports of the mask memory. From input acceptance to o_out_valid a request
// passes the queue register, then the memory read, the 32x32 multiply and
// the accumulate into the output register. A four-entry queue sits between
// the classifying front end and the arithmetic back end.
// After reset the mask memory is set to all good by a pass over its 4096
// entries, during which o_in_stall is high; configuration writes are still
// taken. When the receiver stalls, the result holds and the back end
// freezes; the front end keeps taking requests until its queue is full.
module masked_csr_spmv_top import mcspmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_req              i_in_req,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_res             o_out_res,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    logic clearing;
    logic pop;
    logic head_valid;
    t_cmd head;

    assign o_cfg_ready = 1'b1;

    mcspmv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_req     (i_in_req),
        .o_in_stall   (o_in_stall),
        .i_clearing   (clearing),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    mcspmv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .o_out_res    (o_out_res),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ===== tb/tb_masked_csr_spmv_top.sv =====
module tb_masked_csr_spmv_top;
    import mcspmv_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 280;
    localparam int HOT_COUNT      = 24;
    localparam int HOLD_CYCLES    = 120;
    localparam int TIMEOUT_CYCLES = 300000;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic {STEP_REQ, STEP_CFG} t_step;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} t_rx_mode;

    typedef struct packed {
        t_step                kind;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic                 cfg_data;
        t_in_req              req;
        logic                 known;
        logic signed [63:0]   known_sum;
        logic                 known_sat;
    } t_dir_row;

    localparam t_in_req NO_REQ = '{REQ_VEC_WR, 12'd0, 12'd0, 32'sd0, 1'b0, 1'b0};

    localparam t_dir_row DIR_TAB [25] = '{
        // Vector elements: 1.0, -32768.0, the largest value, -1.0 and 0.5.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_VEC_WR, 12'd0, 12'd0, 32'sh0001_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_VEC_WR, 12'd1, 12'd4095, 32'sh8000_0000, 1'b1, 1'b1},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_VEC_WR, 12'd4095, 12'd0, 32'sh7FFF_FFFF, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_VEC_WR, 12'd2, 12'd0, 32'shFFFF_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_VEC_WR, 12'd3, 12'd0, 32'sh0000_8000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        // Empty rows report zero whatever the other fields hold.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_EMPTY, 12'd0, 12'd0, 32'sd0, 1'b0, 1'b0},
          1'b1, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_EMPTY, 12'd4095, 12'd4095, 32'shFFFF_FFFF, 1'b1, 1'b1},
          1'b1, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd0, 12'd5, 32'sh0003_0000, 1'b0, 1'b1},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd4095, 12'd4095, 32'sh7FFF_FFFF, 1'b1, 1'b1},
          1'b0, 64'sd0, 1'b0},
        // Three products of 2^62 clamp at the positive limit.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd6, 32'sh8000_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd6, 32'sh8000_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd6, 32'sh8000_0000, 1'b0, 1'b1},
          1'b1, SUM_MAX, 1'b1},
        // Three large negative products clamp at the negative limit.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd7, 32'sh7FFF_FFFF, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd7, 32'sh7FFF_FFFF, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd7, 32'sh7FFF_FFFF, 1'b0, 1'b1},
          1'b1, SUM_MIN, 1'b1},
        // A pending partial sum is dropped by an empty row.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd2, 12'd8, 32'sh0001_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_EMPTY, 12'd2, 12'd9, 32'sd0, 1'b0, 1'b0},
          1'b1, 64'sd0, 1'b0},
        // The row number changes before the closing entry.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd3, 12'd10, 32'sh0004_0000, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd0, 12'd11, 32'sh0001_0000, 1'b0, 1'b1},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_MASK_WR, 12'd3, 12'd0, 32'sd0, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_MASK_WR, 12'd11, 12'd0, 32'sd0, 1'b0, 1'b0},
          1'b0, 64'sd0, 1'b0},
        '{STEP_CFG, CFG_COL_MASK, 1'b1, NO_REQ, 1'b0, 64'sd0, 1'b0},
        // A masked column adds nothing but still closes the row.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd3, 12'd12, 32'sh7FFF_FFFF, 1'b0, 1'b1},
          1'b1, 64'sd0, 1'b0},
        '{STEP_CFG, CFG_ROW_SKIP, 1'b1, NO_REQ, 1'b0, 64'sd0, 1'b0},
        // A masked row reports zero.
        '{STEP_REQ, CFG_COL_MASK, 1'b0, '{REQ_ENTRY, 12'd1, 12'd11, 32'sh8000_0000, 1'b0, 1'b1},
          1'b1, 64'sd0, 1'b0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_req              i_in_req    = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_res             o_out_res;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data  = 1'b0;

    masked_csr_spmv_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Image of the block's state, kept by the row predictor.
    logic signed [31:0] vec_img [VEC_DEPTH];
    logic               good_img [VEC_DEPTH];
    logic signed [63:0] acc_img;
    logic               acc_sat_img;
    logic               col_mask_on;
    logic               row_skip_on;

    t_out_res   pending_sums [$];
    logic       vec_seen [VEC_DEPTH];
    logic [11:0] written_cols [$];
    logic [11:0] hot_idx [HOT_COUNT];

    int sent_count   = 0;
    int result_count = 0;
    int sat_count    = 0;
    int err_count    = 0;
    int cfg_writes   = 0;
    int burst_left   = 0;

    function automatic logic predict_row_result(input t_in_req req, output t_out_res res);
        logic signed [31:0] coef;
        logic signed [31:0] elem;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        res = '0;
        case (req.req_type)
            REQ_VEC_WR: vec_img[req.index] = req.value;
            REQ_MASK_WR: good_img[req.index] = req.mask_bit;
            REQ_EMPTY: begin
                acc_img = '0;
                acc_sat_img = 1'b0;
                res.result_row = req.row_number;
                return 1'b1;
            end
            REQ_ENTRY: begin
                if (!(col_mask_on && !good_img[req.index])) begin
                    coef = req.value;
                    elem = vec_img[req.index];
                    prod = coef * elem;
                    sum = acc_img + prod;
                    if (acc_img[63] == prod[63] && sum[63] != acc_img[63]) begin
                        acc_sat_img = 1'b1;
                        sum = acc_img[63] ? SUM_MIN : SUM_MAX;
                    end
                    acc_img = sum;
                end
                if (req.last_in_row) begin
                    res.result_row = req.row_number;
                    if (!(row_skip_on && !good_img[req.row_number])) begin
                        res.row_sum = acc_img;
                        res.saturated = acc_sat_img;
                    end
                    acc_img = '0;
                    acc_sat_img = 1'b0;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5, 6: return int'($urandom_range(0, 2097151)) - 1048576;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a small pool, so that mask writes land on columns and rows in use.
    function automatic logic [11:0] pick_idx();
        if ($urandom_range(0, 4) != 0)
            return hot_idx[$urandom_range(0, HOT_COUNT - 1)];
        return 12'($urandom_range(0, VEC_DEPTH - 1));
    endfunction

    // Columns come only from vector elements already written.
    function automatic logic [11:0] pick_col();
        return written_cols[$urandom_range(0, written_cols.size() - 1)];
    endfunction

    function automatic t_in_req rand_req();
        t_in_req r;
        r.req_type    = 2'($urandom_range(0, 3));
        r.index       = 12'($urandom);
        r.row_number  = 12'($urandom);
        r.value       = $urandom;
        r.mask_bit    = 1'($urandom);
        r.last_in_row = 1'($urandom);
        return r;
    endfunction

    task automatic send_req(input t_in_req req, input logic known, input t_out_res known_res);
        int gap;
        t_out_res res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        if (req.req_type == REQ_VEC_WR && !vec_seen[req.index]) begin
            vec_seen[req.index] = 1'b1;
            written_cols.insert(written_cols.size(), req.index);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_count++;
        if (predict_row_result(req, res))
            pending_sums.insert(pending_sums.size(), known ? known_res : res);
    endtask

    // Lets every pending request drain before a register changes.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_COL_MASK: col_mask_on = data;
            CFG_ROW_SKIP: row_skip_on = data;
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic col_mask, input logic row_skip);
        int start;
        int pick;
        int len;
        logic [11:0] row;
        t_in_req r;
        settle();
        write_reg(CFG_COL_MASK, col_mask);
        write_reg(CFG_ROW_SKIP, row_skip);
        start = sent_count;
        while (sent_count - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            r = rand_req();
            if (pick < 8) begin
                r.req_type = REQ_VEC_WR;
                r.index = pick_idx();
                r.value = rand_value();
                send_req(r, 1'b0, '0);
            end else if (pick < 16) begin
                r.req_type = REQ_MASK_WR;
                r.index = pick_idx();
                send_req(r, 1'b0, '0);
            end else if (pick < 80) begin
                row = pick_idx();
                len = $urandom_range(0, 5);
                if (len == 0) begin
                    r.req_type = REQ_EMPTY;
                    r.row_number = row;
                    send_req(r, 1'b0, '0);
                end
                for (int k = 0; k < len; k++) begin
                    r = rand_req();
                    r.req_type = REQ_ENTRY;
                    r.index = pick_col();
                    r.row_number = row;
                    r.value = rand_value();
                    r.last_in_row = (k == len - 1);
                    send_req(r, 1'b0, '0);
                end
            end else if (pick < 92) begin
                // Unclosed entries, then either an empty row or the next row absorbs them.
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    r = rand_req();
                    r.req_type = REQ_ENTRY;
                    r.index = pick_col();
                    r.row_number = pick_idx();
                    r.value = rand_value();
                    r.last_in_row = 1'b0;
                    send_req(r, 1'b0, '0);
                end
                if ($urandom_range(0, 1) == 1) begin
                    r = rand_req();
                    r.req_type = REQ_EMPTY;
                    send_req(r, 1'b0, '0);
                end
            end else begin
                if (r.req_type == REQ_ENTRY)
                    r.index = pick_col();
                send_req(r, 1'b0, '0);
            end
        end
    endtask

    // Output monitor: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            result_count++;
            if (o_out_res.saturated === 1'b1)
                sat_count++;
            if (pending_sums.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result row %0d sum %0d sat %0b", $time,
                         o_out_res.result_row, o_out_res.row_sum, o_out_res.saturated);
            end else begin
                want = pending_sums.pop_front();
                if (o_out_res.result_row !== want.result_row) begin
                    err_count++;
                    $display("%0t: result_row expected %0d actual %0d", $time,
                             want.result_row, o_out_res.result_row);
                end
                if (o_out_res.row_sum !== want.row_sum) begin
                    err_count++;
                    $display("%0t: row_sum of row %0d expected %0d actual %0d", $time,
                             want.result_row, want.row_sum, o_out_res.row_sum);
                end
                if (o_out_res.saturated !== want.saturated) begin
                    err_count++;
                    $display("%0t: saturated of row %0d expected %0b actual %0b", $time,
                             want.result_row, want.saturated, o_out_res.saturated);
                end
            end
        end
    end

    // Receiver stall pattern; every sixth stretch is a long hold that backs up the queue.
    initial begin
        int seg;
        int len;
        t_rx_mode mode;
        seg = 0;
        forever begin
            seg++;
            if (seg % 6 == 0) begin
                mode = RX_HOLD;
                len = HOLD_CYCLES;
            end else begin
                mode = t_rx_mode'($urandom_range(0, 2));
                len = $urandom_range(10, 150);
            end
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    RX_FREE: i_out_stall <= 1'b0;
                    RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("masked_csr_spmv_top verification failed");
        $finish;
    end

    initial begin
        t_in_req r;
        t_out_res known_res;
        for (int i = 0; i < VEC_DEPTH; i++) begin
            vec_img[i] = '0;
            good_img[i] = 1'b1;
            vec_seen[i] = 1'b0;
        end
        acc_img = '0;
        acc_sat_img = 1'b0;
        col_mask_on = 1'b0;
        row_skip_on = 1'b0;
        hot_idx[0] = 12'd0;
        hot_idx[1] = 12'd4095;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_idx[i] = 12'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(DIR_TAB); i++) begin
            if (DIR_TAB[i].kind == STEP_CFG) begin
                settle();
                write_reg(DIR_TAB[i].cfg_index, DIR_TAB[i].cfg_data);
            end else begin
                known_res = '{DIR_TAB[i].req.row_number, DIR_TAB[i].known_sum,
                              DIR_TAB[i].known_sat};
                send_req(DIR_TAB[i].req, DIR_TAB[i].known, known_res);
            end
        end

        // Every pooled index gets a vector element before the random rows use it.
        for (int i = 0; i < HOT_COUNT; i++) begin
            r = rand_req();
            r.req_type = REQ_VEC_WR;
            r.index = hot_idx[i];
            r.value = rand_value();
            send_req(r, 1'b0, '0);
        end

        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b1);
        run_phase(1'b1, 1'b0);
        run_phase(1'b0, 1'b1);
        run_phase(1'($urandom), 1'($urandom));
        run_phase(1'($urandom), 1'($urandom));
        settle();

        $display("Sent %0d requests over %0d register writes; checked %0d row results,",
                 sent_count, cfg_writes, result_count);
        $display("%0d of them saturated, with column masking and row skipping both toggled.",
                 sat_count);
        if (err_count == 0 && pending_sums.size() == 0) begin
            $display("masked_csr_spmv_top verification clean");
        end else begin
            $display("masked_csr_spmv_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mcspmv_pkg.sv
src/mcspmv_front.sv
src/mcspmv_back.sv
src/masked_csr_spmv_top.sv
tb/tb_masked_csr_spmv_top.sv
